// File: hw/rtl/rgb_led_uart_symbol_encoder_top_assert.svh
// Assertion macros for the RGB LED UART symbol encoder.
// Included by the encoder top module to check its own logic; depends on nothing else.
`ifndef RGB_LED_UART_SYMBOL_ENCODER_TOP_ASSERT_SVH
`define RGB_LED_UART_SYMBOL_ENCODER_TOP_ASSERT_SVH

// A condition that must hold in the same cycle as its trigger.
`define RLSE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rlse assertion failed");

// A condition that must hold in the cycle after its trigger.
`define RLSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rlse assertion failed");

`endif

// File: hw/rtl/rlse_pkg.sv
// Package for the RGB LED UART symbol encoder: beat types, register map
// and the percent to level conversion. Depends on nothing.
package rlse_pkg;

    localparam int unsigned CFG_ADDR_W    = 4;
    localparam int unsigned CFG_DATA_W    = 32;
    localparam int unsigned BYTES_PER_LED = 8;

    localparam logic [1:0] REG_LED_COUNT = 2'd0;
    localparam logic [1:0] REG_ONE_CODE  = 2'd1;
    localparam logic [1:0] REG_ZERO_CODE = 2'd2;

    localparam logic [7:0] RST_LED_COUNT = 8'd1;
    localparam logic [2:0] RST_ONE_CODE  = 3'd6;
    localparam logic [2:0] RST_ZERO_CODE = 3'd4;

    // Division by 100 done as a multiply by a rounded-up reciprocal and a shift;
    // exact for every numerator below 43690, well above the largest one here.
    localparam logic [15:0] LEVEL_RECIP = 16'd41944;
    localparam int unsigned LEVEL_SHIFT = 22;
    localparam logic [6:0]  PERCENT_MAX = 7'd100;

    typedef struct packed {
        logic [6:0] green_percent;
        logic [6:0] red_percent;
        logic [6:0] blue_percent;
    } t_led_in;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
        logic       led_last;
    } t_sym_out;

    // round(p * 255 / 100), saturating to full level above one hundred percent.
    function automatic logic [7:0] percent_to_level(input logic [6:0] p);
        logic [14:0] num;
        logic [30:0] prod;
        num  = ({p, 8'd0} - {8'd0, p}) + 15'd50;
        prod = {16'd0, num} * {15'd0, LEVEL_RECIP};
        if (p > PERCENT_MAX) begin
            return 8'hFF;
        end
        return prod[LEVEL_SHIFT +: 8];
    endfunction

endpackage

// File: hw/rtl/rgb_led_uart_symbol_encoder_top.sv
// Each LED beat (green, red, blue percent) is turned into eight UART bytes,
// three LED data bits per byte, sent one byte per clock while i_stall is low; the LED that completes
// a frame of led_count LEDs is followed by a ninth, trailer byte with frame_end
// set. All bytes pass through the single byte-wide serialiser feeding the output
// register. One LED waits in the input register while the previous one is
// serialised, so the next LED is loaded in the cycle the last byte leaves.
// A beat goes from the input register through the serialiser to the output
// register. Registers are written over APB: led_count at 0x0, one_bit_code at 0x4,
// zero_bit_code at 0x8; they should only be changed while no LED is in flight.
// Depends on rlse_pkg and rgb_led_uart_symbol_encoder_top_assert.svh.
module rgb_led_uart_symbol_encoder_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  rlse_pkg::t_led_in                  i_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output rlse_pkg::t_sym_out                 o_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rlse_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [rlse_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [rlse_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import rlse_pkg::*;

    `include "rgb_led_uart_symbol_encoder_top_assert.svh"

    localparam logic [3:0] IDX_LAST_DATA = 4'(BYTES_PER_LED - 1);
    localparam logic [3:0] IDX_TRAILER   = 4'(BYTES_PER_LED);

    // Configuration registers
    logic [7:0] r_led_count;
    logic [2:0] r_one_code;
    logic [2:0] r_zero_code;

    // Frame position
    logic [7:0] r_led_pos;
    logic [8:0] n_sent;
    logic       n_ends;

    // Input holding register
    logic    r_in_valid;
    t_led_in r_in;

    // Serialiser
    logic        r_busy;
    logic        r_ends;
    logic [3:0]  r_idx;
    logic [23:0] r_word;
    logic [23:0] n_word;

    // Output register
    logic     r_out_valid;
    t_sym_out r_out;
    t_sym_out n_out;

    logic out_adv;
    logic ser_last;
    logic ser_done;
    logic load;
    logic in_take;
    logic cfg_wr;

    logic [2:0] code_a;
    logic [2:0] code_b;
    logic [2:0] code_c;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            REG_LED_COUNT: prdata = {24'd0, r_led_count};
            REG_ONE_CODE:  prdata = {29'd0, r_one_code};
            REG_ZERO_CODE: prdata = {29'd0, r_zero_code};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= RST_LED_COUNT;
            r_one_code  <= RST_ONE_CODE;
            r_zero_code <= RST_ZERO_CODE;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_LED_COUNT: r_led_count <= pwdata[7:0];
                REG_ONE_CODE:  r_one_code  <= pwdata[2:0];
                REG_ZERO_CODE: r_zero_code <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Handshake and serialiser control
    assign out_adv  = !r_out_valid || !i_stall;
    assign ser_last = ((r_idx == IDX_LAST_DATA) && !r_ends) || (r_idx == IDX_TRAILER);
    assign ser_done = r_busy && out_adv && ser_last;
    assign load     = r_in_valid && (!r_busy || ser_done);
    assign o_stall  = r_in_valid && !load;
    assign in_take  = i_valid && !o_stall;

    // A position of 255 gives 256 sent, which ends the frame for every count.
    assign n_sent = {1'b0, r_led_pos} + 9'd1;
    assign n_ends = n_sent >= {1'b0, r_led_count};

    assign n_word = {percent_to_level(r_in.green_percent),
                     percent_to_level(r_in.red_percent),
                     percent_to_level(r_in.blue_percent)};

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_busy     <= 1'b0;
            r_ends     <= 1'b0;
            r_idx      <= '0;
            r_led_pos  <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end

            if (load) begin
                r_busy    <= 1'b1;
                r_ends    <= n_ends;
                r_idx     <= '0;
                r_led_pos <= n_ends ? 8'd0 : n_sent[7:0];
            end else if (ser_done) begin
                r_busy <= 1'b0;
            end else if (r_busy && out_adv) begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    // The level word shifts up by three bits for every byte sent.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= n_word;
        end else if (r_busy && out_adv) begin
            r_word <= {r_word[20:0], 3'd0};
        end
    end

    // The earliest bit of a byte goes in its low two bits, the latest in the top three.
    assign code_c = r_word[23] ? r_one_code : r_zero_code;
    assign code_b = r_word[22] ? r_one_code : r_zero_code;
    assign code_a = r_word[21] ? r_one_code : r_zero_code;

    always_comb begin
        n_out.led_last  = ser_last;
        n_out.frame_end = (r_idx == IDX_TRAILER);
        if (r_idx == IDX_TRAILER) begin
            n_out.tx_byte = {r_zero_code, r_zero_code, r_zero_code[2:1]};
        end else begin
            n_out.tx_byte = {code_a, code_b, code_c[2:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_busy && out_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && out_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `RLSE_ASSERT_IMPLY(a_trailer_is_last, i_clk, i_rst_n, r_out_valid && r_out.frame_end, r_out.led_last)
    `RLSE_ASSERT_IMPLY(a_no_trailer_idx, i_clk, i_rst_n, r_busy && !r_ends, r_idx <= IDX_LAST_DATA)
    `RLSE_ASSERT_IMPLY(a_stall_only_full, i_clk, i_rst_n, o_stall, r_in_valid && r_busy)
    `RLSE_ASSERT_IMPLY(a_frame_restarts, i_clk, i_rst_n, r_busy && r_ends, r_led_pos == 8'd0)
    `RLSE_ASSERT_NEXT(a_done_emits_last, i_clk, i_rst_n, ser_done, r_out_valid && r_out.led_last)

endmodule
